// ----- sv/rbj_pkg.sv -----
package rbj_pkg;

    localparam int unsigned XLEN = 32;

    localparam logic [1:0] MODE_JALR   = 2'd0;
    localparam logic [1:0] MODE_BRANCH = 2'd1;
    localparam logic [1:0] MODE_JAL    = 2'd2;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [1:0] EXC_NONE      = 2'd0;
    localparam logic [1:0] EXC_MISALIGN  = 2'd1;
    localparam logic [1:0] EXC_ILLEGAL   = 2'd2;

    // decoded word, first stage to second
    typedef struct packed {
        logic [1:0]      mode;
        logic [2:0]      funct3;
        logic [XLEN-1:0] base;
        logic [XLEN-1:0] offset;
        logic [XLEN-1:0] rs1;
        logic [XLEN-1:0] rs2;
        logic [XLEN-1:0] link_value;
        logic [XLEN-1:0] inst_word;
        logic [4:0]      dest_reg;
    } t_dec;

    // evaluated word, second stage to third
    typedef struct packed {
        logic            take;
        logic            link;
        logic            illegal;
        logic [XLEN-1:0] target;
        logic [XLEN-1:0] link_value;
        logic [XLEN-1:0] inst_word;
        logic [4:0]      dest_reg;
    } t_eval;

    // result word
    typedef struct packed {
        logic            redirect;
        logic [XLEN-1:0] target_pc;
        logic            link_write;
        logic [4:0]      link_reg;
        logic [XLEN-1:0] link_value;
        logic [1:0]      exc_code;
        logic [XLEN-1:0] exc_value;
    } t_res;

endpackage

// ----- sv/rbj_decode.sv -----
module rbj_decode
    import rbj_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_mode,
    input  logic [2:0]       i_funct3,
    input  logic [11:0]      i_imm_i,
    input  logic [4:0]       i_imm_low5,
    input  logic [6:0]       i_imm_high7,
    input  logic [19:0]      i_imm_j,
    input  logic [4:0]       i_dest_reg,
    input  logic [XLEN-1:0]  i_pc_value,
    input  logic [XLEN-1:0]  i_rs1_value,
    input  logic [XLEN-1:0]  i_rs2_value,
    input  logic [XLEN-1:0]  i_inst_word,
    output logic             o_valid,
    input  logic             i_stall,
    output t_dec             o_dec
);

    logic            r_valid;
    t_dec            r_dec;
    t_dec            n_dec;
    logic [XLEN-1:0] imm_i_ext;
    logic [XLEN-1:0] imm_b_ext;
    logic [XLEN-1:0] imm_j_ext;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

    assign imm_i_ext = {{(XLEN-12){i_imm_i[11]}}, i_imm_i};
    assign imm_b_ext = {{(XLEN-13){i_imm_high7[6]}}, i_imm_high7[6], i_imm_low5[0],
                        i_imm_high7[5:0], i_imm_low5[4:1], 1'b0};
    assign imm_j_ext = {{(XLEN-21){i_imm_j[19]}}, i_imm_j[19], i_imm_j[7:0], i_imm_j[8],
                        i_imm_j[18:9], 1'b0};

    always_comb begin
        n_dec            = '0;
        n_dec.mode       = i_mode;
        n_dec.funct3     = i_funct3;
        n_dec.rs1        = i_rs1_value;
        n_dec.rs2        = i_rs2_value;
        n_dec.link_value = i_pc_value + XLEN'(4);
        n_dec.inst_word  = i_inst_word;
        n_dec.dest_reg   = i_dest_reg;
        case (i_mode)
            MODE_JALR: begin
                n_dec.base   = i_rs1_value;
                n_dec.offset = imm_i_ext;
            end
            MODE_BRANCH: begin
                n_dec.base   = i_pc_value;
                n_dec.offset = imm_b_ext;
            end
            MODE_JAL: begin
                n_dec.base   = i_pc_value;
                n_dec.offset = imm_j_ext;
            end
            default: begin
                // unknown mode: target reads as zero
                n_dec.base   = '0;
                n_dec.offset = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_dec <= n_dec;
        end
    end

endmodule

// ----- sv/rbj_exec.sv -----
module rbj_exec
    import rbj_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_dec  i_dec,
    output logic  o_valid,
    input  logic  i_stall,
    output t_eval o_eval
);

    logic            r_valid;
    t_eval           r_eval;
    t_eval           n_eval;
    logic [XLEN-1:0] sum;
    logic            eq;
    logic            lt_s;
    logic            lt_u;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_eval  = r_eval;

    assign sum  = i_dec.base + i_dec.offset;
    assign eq   = (i_dec.rs1 == i_dec.rs2);
    assign lt_s = ($signed(i_dec.rs1) < $signed(i_dec.rs2));
    assign lt_u = (i_dec.rs1 < i_dec.rs2);

    always_comb begin
        n_eval            = '0;
        n_eval.target     = sum;
        n_eval.link_value = i_dec.link_value;
        n_eval.inst_word  = i_dec.inst_word;
        n_eval.dest_reg   = i_dec.dest_reg;
        case (i_dec.mode)
            MODE_JALR: begin
                n_eval.target = {sum[XLEN-1:1], 1'b0};
                n_eval.take   = 1'b1;
                n_eval.link   = 1'b1;
            end
            MODE_BRANCH: begin
                case (i_dec.funct3)
                    F3_BEQ:  n_eval.take = eq;
                    F3_BNE:  n_eval.take = !eq;
                    F3_BLT:  n_eval.take = lt_s;
                    F3_BGE:  n_eval.take = !lt_s;
                    F3_BLTU: n_eval.take = lt_u;
                    F3_BGEU: n_eval.take = !lt_u;
                    default: n_eval.illegal = 1'b1;
                endcase
            end
            MODE_JAL: begin
                n_eval.take = 1'b1;
                n_eval.link = 1'b1;
            end
            default: begin
                n_eval.illegal = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_eval <= n_eval;
        end
    end

endmodule

// ----- sv/rbj_resolve.sv -----
module rbj_resolve
    import rbj_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_eval i_eval,
    output logic  o_valid,
    input  logic  i_stall,
    output t_res  o_res
);

    logic r_valid;
    t_res r_res;
    t_res n_res;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_res            = '0;
        n_res.target_pc  = i_eval.target;
        n_res.link_reg   = i_eval.dest_reg;
        n_res.link_value = i_eval.link_value;
        n_res.exc_code   = EXC_NONE;
        if (i_eval.illegal) begin
            n_res.exc_code  = EXC_ILLEGAL;
            n_res.exc_value = i_eval.inst_word;
        end else if (i_eval.take) begin
            // a faulting transfer neither redirects nor links
            if (i_eval.target[1:0] != 2'b00) begin
                n_res.exc_code  = EXC_MISALIGN;
                n_res.exc_value = i_eval.target;
            end else begin
                n_res.redirect   = 1'b1;
                n_res.link_write = i_eval.link;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_res <= n_res;
        end
    end

endmodule

// ----- sv/rv32i_branch_jump_unit.sv -----
// RV32I control-transfer unit for JALR, the six conditional branches and JAL. It takes one
// word per cycle and passes it through its pipeline stages: the first stage sign-extends
// the immediate and picks the base, the second does the 32-bit target add and the operand
// compares, the third resolves faults and holds the output word. Every stage has its own
// valid bit, and a stall on the output backs up through the stages without losing a word,
// so throughput stays at one word per cycle whenever the consumer keeps up. There is no
// state beyond the pipeline registers.
module rv32i_branch_jump_unit
    import rbj_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_mode,
    input  logic [2:0]      i_funct3,
    input  logic [11:0]     i_imm_i,
    input  logic [4:0]      i_imm_low5,
    input  logic [6:0]      i_imm_high7,
    input  logic [19:0]     i_imm_j,
    input  logic [4:0]      i_dest_reg,
    input  logic [XLEN-1:0] i_pc_value,
    input  logic [XLEN-1:0] i_rs1_value,
    input  logic [XLEN-1:0] i_rs2_value,
    input  logic [XLEN-1:0] i_inst_word,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_redirect,
    output logic [XLEN-1:0] o_target_pc,
    output logic            o_link_write,
    output logic [4:0]      o_link_reg,
    output logic [XLEN-1:0] o_link_value,
    output logic [1:0]      o_exc_code,
    output logic [XLEN-1:0] o_exc_value
);

    logic  dec_valid;
    logic  dec_stall;
    t_dec  dec;
    logic  exe_valid;
    logic  exe_stall;
    t_eval eval;
    t_res  res;

    rbj_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_funct3    (i_funct3),
        .i_imm_i     (i_imm_i),
        .i_imm_low5  (i_imm_low5),
        .i_imm_high7 (i_imm_high7),
        .i_imm_j     (i_imm_j),
        .i_dest_reg  (i_dest_reg),
        .i_pc_value  (i_pc_value),
        .i_rs1_value (i_rs1_value),
        .i_rs2_value (i_rs2_value),
        .i_inst_word (i_inst_word),
        .o_valid     (dec_valid),
        .i_stall     (dec_stall),
        .o_dec       (dec)
    );

    rbj_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_stall (dec_stall),
        .i_dec   (dec),
        .o_valid (exe_valid),
        .i_stall (exe_stall),
        .o_eval  (eval)
    );

    rbj_resolve u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (exe_valid),
        .o_stall (exe_stall),
        .i_eval  (eval),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    assign o_redirect   = res.redirect;
    assign o_target_pc  = res.target_pc;
    assign o_link_write = res.link_write;
    assign o_link_reg   = res.link_reg;
    assign o_link_value = res.link_value;
    assign o_exc_code   = res.exc_code;
    assign o_exc_value  = res.exc_value;

endmodule

// ----- sv/rbj_checker.sv -----
module rbj_checker
    import rbj_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic            o_redirect,
    input logic [XLEN-1:0] o_target_pc,
    input logic            o_link_write,
    input logic [1:0]      o_exc_code,
    input logic [XLEN-1:0] o_exc_value
);

    // a held word keeps its outcome
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_redirect) && $stable(o_exc_code)
            && $stable(o_target_pc))
        else $error("stalled result changed");

    a_redirect_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_redirect |-> o_exc_code == EXC_NONE && o_target_pc[1:0] == 2'b00)
        else $error("redirect with fault or misaligned target");

    a_link_needs_redirect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_link_write |-> o_redirect)
        else $error("link write without redirect");

    a_exc_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_exc_code == EXC_MISALIGN |-> o_exc_value == o_target_pc && !o_redirect)
        else $error("misaligned fault does not report its target");

    // no backpressure reaches the input while the output drains freely
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall && $past(!i_stall) && $past(!i_stall, 2) && i_rst_n && $past(i_rst_n)
            |-> !o_stall)
        else $error("input stalled with free output");

endmodule

bind rv32i_branch_jump_unit rbj_checker u_rbj_checker (.*);
